// File: rtl/cffp_pkg.sv
// Shared types and constants of the circular first-fit placement core.
`default_nettype none

package cffp_pkg;

    localparam int ARENA_BYTES_DEF = 4096;

    localparam int ADDR_W  = 12;
    localparam int VALUE_W = 8;
    localparam int SIZE_W  = 13;
    localparam int COUNT_W = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREF,
        ST_SCAN,
        ST_FINISH
    } cffp_state_t;

endpackage

`default_nettype wire

// File: rtl/cffp_ifs.sv
// Valid/ready channel interfaces for query/write words and placement results.
`default_nettype none

interface cffp_in_if;
    import cffp_pkg::*;

    logic               valid;
    logic               ready;
    logic               opcode;
    logic [ADDR_W-1:0]  byte_addr;
    logic [VALUE_W-1:0] byte_value;
    logic [SIZE_W-1:0]  block_size;
    logic [COUNT_W-1:0] placed_count;

    modport source (
        output valid, opcode, byte_addr, byte_value, block_size, placed_count,
        input  ready
    );

    modport sink (
        input  valid, opcode, byte_addr, byte_value, block_size, placed_count,
        output ready
    );
endinterface

interface cffp_out_if;
    import cffp_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [ADDR_W-1:0] place_addr;

    modport source (
        output valid, found, place_addr,
        input  ready
    );

    modport sink (
        input  valid, found, place_addr,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/circular_first_fit_placement_core.sv
// Top level: circular arena occupancy memory with first-fit placement search.
//
//  channel  | dir | word contents
//  ---------+-----+---------------------------------------------------------
//  in_ch    | in  | opcode, byte_addr, byte_value, block_size, placed_count
//  out_ch   | out | found, place_addr (one word per query, none per write)
//
// After reset a clearing pass writes every arena entry, during which no word
// is accepted. A write goes to the arena as it is accepted. A query is taken,
// then tests the preferred start and, if that fails, runs the lowest-start
// scan, then loads the output register; a zero count or zero size skips both walks.
// One word is in work at a time; a finished result waits in the output
// register while the next word is taken, and a second finished query holds
// the core, and with it the input, until the first result is taken.
`default_nettype none

module circular_first_fit_placement_core #(
    parameter int ARENA_BYTES = cffp_pkg::ARENA_BYTES_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    cffp_in_if.sink           in_ch,
    cffp_out_if.source        out_ch
);
    import cffp_pkg::*;

    localparam int AW  = $clog2(ARENA_BYTES);
    localparam int LW  = $clog2(ARENA_BYTES + 1);
    localparam int CW  = $clog2(2 * ARENA_BYTES);
    localparam int LXW = (LW > SIZE_W) ? LW : SIZE_W;
    localparam int XW  = (AW > ADDR_W) ? AW : ADDR_W;
    localparam int QUARTER = ARENA_BYTES / 4;
    // Compare-subtract steps that fold a byte address into the arena.
    localparam int NSTEP = (ARENA_BYTES >= 4096) ? 1 : $clog2(4096 / ARENA_BYTES) + 1;

    // Only the zero/nonzero property of a byte affects placement, so one bit
    // per arena byte is stored.
    logic arena_mem [ARENA_BYTES];

    cffp_state_t     state_reg, state_next;
    logic [AW-1:0]   addr_reg, addr_next;
    logic [CW-1:0]   iss_reg, iss_next;
    logic [CW-1:0]   chk_reg, chk_next;
    logic            dv_reg, dv_next;
    logic            rd_data_reg;
    logic [LW-1:0]   len_reg, len_next;
    logic [LW-1:0]   run_reg, run_next;
    logic [CW-1:0]   pos_reg, pos_next;
    logic [CW-1:0]   cand_reg, cand_next;
    logic            res_found_reg, res_found_next;
    logic [AW-1:0]   res_addr_reg, res_addr_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_found_reg, out_found_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    logic            mem_we;
    logic [AW-1:0]   mem_wa;
    logic            mem_wd;

    logic [LXW-1:0]  size_x;
    logic [LW-1:0]   req_len;
    logic [CW-1:0]   pref_prod;
    logic [AW-1:0]   pref_start;
    logic [AW-1:0]   addr_inc;
    logic [CW-1:0]   scan_total;
    logic [XW-1:0]   res_addr_x;

    function automatic logic [AW-1:0] fold_addr(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] r;
        r = {1'b0, a};
        if (ARENA_BYTES < 4096)
        begin
            for (int k = NSTEP - 1; k >= 0; k--)
            begin
                if (r >= (ADDR_W+1)'(ARENA_BYTES << k))
                begin
                    r = r - (ADDR_W+1)'(ARENA_BYTES << k);
                end
            end
        end
        return AW'(r);
    endfunction

    assign size_x  = LXW'(in_ch.block_size);
    assign req_len = (size_x > LXW'(ARENA_BYTES)) ? LW'(ARENA_BYTES) : LW'(size_x);

    // count * quarter stays below twice the arena, so one subtraction folds it.
    assign pref_prod  = CW'(in_ch.placed_count) * CW'(QUARTER);
    assign pref_start = (pref_prod >= CW'(ARENA_BYTES))
                        ? AW'(pref_prod - CW'(ARENA_BYTES)) : AW'(pref_prod);

    assign addr_inc   = (addr_reg == AW'(ARENA_BYTES - 1)) ? '0 : addr_reg + AW'(1);
    assign scan_total = CW'(ARENA_BYTES) + CW'(len_reg) - CW'(1);
    assign res_addr_x = XW'(res_addr_reg);

    assign in_ch.ready       = (state_reg == ST_IDLE);
    assign out_ch.valid      = out_valid_reg;
    assign out_ch.found      = out_found_reg;
    assign out_ch.place_addr = out_addr_reg;

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        dv_next        = 1'b0;
        len_next       = len_reg;
        run_next       = run_reg;
        pos_next       = pos_reg;
        cand_next      = cand_reg;
        res_found_next = res_found_reg;
        res_addr_next  = res_addr_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_found_next = out_found_reg;
        out_addr_next  = out_addr_reg;
        mem_we         = 1'b0;
        mem_wa         = addr_reg;
        mem_wd         = 1'b0;

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                addr_next = addr_inc;
                if (addr_reg == AW'(ARENA_BYTES - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.opcode == OP_WRITE)
                    begin
                        mem_we = 1'b1;
                        mem_wa = fold_addr(in_ch.byte_addr);
                        mem_wd = |in_ch.byte_value;
                    end
                    else if (in_ch.placed_count == '0)
                    begin
                        res_found_next = 1'b1;
                        res_addr_next  = '0;
                        state_next     = ST_FINISH;
                    end
                    else if (req_len == '0)
                    begin
                        res_found_next = 1'b1;
                        res_addr_next  = pref_start;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        res_addr_next = pref_start;
                        addr_next     = pref_start;
                        iss_next      = CW'(req_len);
                        chk_next      = CW'(req_len);
                        len_next      = req_len;
                        state_next    = ST_PREF;
                    end
                end
            end

            ST_PREF:
            begin
                if (iss_reg != '0)
                begin
                    addr_next = addr_inc;
                    iss_next  = iss_reg - CW'(1);
                    dv_next   = 1'b1;
                end
                if (dv_reg)
                begin
                    if (rd_data_reg)
                    begin
                        // Preferred run is busy: restart as a scan from address zero.
                        addr_next  = '0;
                        iss_next   = scan_total;
                        chk_next   = scan_total;
                        dv_next    = 1'b0;
                        run_next   = '0;
                        pos_next   = '0;
                        cand_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else if (chk_reg == CW'(1))
                    begin
                        res_found_next = 1'b1;
                        dv_next        = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        chk_next = chk_reg - CW'(1);
                    end
                end
            end

            ST_SCAN:
            begin
                if (iss_reg != '0)
                begin
                    addr_next = addr_inc;
                    iss_next  = iss_reg - CW'(1);
                    dv_next   = 1'b1;
                end
                if (dv_reg)
                begin
                    pos_next = pos_reg + CW'(1);
                    chk_next = chk_reg - CW'(1);
                    // The first position that closes a zero run of len bytes
                    // gives the lowest start, since all runs have equal length.
                    if (!rd_data_reg && (run_reg + LW'(1) == len_reg))
                    begin
                        res_found_next = 1'b1;
                        res_addr_next  = AW'(cand_reg);
                        dv_next        = 1'b0;
                        state_next     = ST_FINISH;
                    end
                    else
                    begin
                        if (rd_data_reg)
                        begin
                            run_next  = '0;
                            cand_next = pos_reg + CW'(1);
                        end
                        else
                        begin
                            run_next = run_reg + LW'(1);
                        end
                        if (chk_reg == CW'(1))
                        begin
                            res_found_next = 1'b0;
                            res_addr_next  = '0;
                            dv_next        = 1'b0;
                            state_next     = ST_FINISH;
                        end
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_found_next = res_found_reg;
                    out_addr_next  = res_addr_x[ADDR_W-1:0];
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            addr_reg      <= '0;
            iss_reg       <= '0;
            chk_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            iss_reg       <= iss_next;
            chk_reg       <= chk_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg       <= len_next;
        run_reg       <= run_next;
        pos_reg       <= pos_next;
        cand_reg      <= cand_next;
        res_found_reg <= res_found_next;
        res_addr_reg  <= res_addr_next;
        out_found_reg <= out_found_next;
        out_addr_reg  <= out_addr_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            arena_mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= arena_mem[addr_reg];
    end

    // A read result is only pending while a walk over the arena is running.
    a_dv_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        dv_reg |-> (state_reg == ST_PREF || state_reg == ST_SCAN))
        else $error("read data flagged outside an arena walk");

    a_chk_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREF || state_reg == ST_SCAN) |-> chk_reg != '0)
        else $error("check counter ran out during a walk");

    a_run_short: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> run_reg < len_reg)
        else $error("zero run reached the size without a hit");

    a_cand_in_arena: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && dv_reg && !rd_data_reg && run_reg + LW'(1) == len_reg)
        |-> cand_reg < CW'(ARENA_BYTES))
        else $error("chosen start lies beyond the arena");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("result word appeared without a finished query");

endmodule

`default_nettype wire
